FILE: rtl/cpfd_pkg.sv
// ----------------------------------------------------------------------------
// cpfd_pkg
// Shared constants, codes and types of the packet fragment deframer.
// ----------------------------------------------------------------------------
package cpfd_pkg;

  // Width of the byte position and byte counters
  localparam int POSITION_BITS = 22;

  localparam int CFG_IDX_W = 8;
  localparam int TOTAL_W   = 22;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DESK_CHANNEL   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL_SIZE = CFG_IDX_W'(1);

  localparam logic [31:0]        DESK_CHANNEL_RST   = 32'd10;
  localparam logic [TOTAL_W-1:0] MAX_TOTAL_SIZE_RST = 22'h241800;

  // Parser phases
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_CHANNEL = 3'd1;
  localparam logic [2:0] PH_FRAGHDR = 3'd2;
  localparam logic [2:0] PH_DATA    = 3'd3;
  localparam logic [2:0] PH_SKIP    = 3'd4;

  localparam logic [31:0] DATA_MAGIC   = 32'h43504b54;
  localparam logic [31:0] LENGTH_SLACK = 32'h00010000;
  localparam logic [31:0] GROUP_BYTES  = 32'd12;
  localparam logic [31:0] MIN_CHAN_LEN = 32'd4;

  // Byte counter marks within a word group
  localparam logic [3:0] FC_WORD1_START = 4'd4;
  localparam logic [3:0] FC_WORD2_START = 4'd8;
  localparam logic [3:0] FC_WORD_LAST   = 4'd3;
  localparam logic [3:0] FC_GROUP_LAST  = 4'd11;

  typedef struct packed {
    logic [31:0]        desk_channel;
    logic [TOTAL_W-1:0] max_total_size;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         frag_byte;
    logic [31:0]        frag_sequence;
    logic [TOTAL_W-1:0] byte_position;
    logic [TOTAL_W-1:0] record_total;
    logic               last_of_fragment;
    logic               fault;
  } frag_t;

  typedef struct packed {
    logic  valid;
    frag_t frag;
  } res_t;

endpackage

FILE: rtl/cpfd_byte_if.sv
// ----------------------------------------------------------------------------
// cpfd_byte_if
// Raw stream byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

FILE: rtl/cpfd_frag_if.sv
// ----------------------------------------------------------------------------
// cpfd_frag_if
// Fragment result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpfd_frag_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frag_byte;
  logic [31:0] frag_sequence;
  logic [21:0] byte_position;
  logic [21:0] record_total;
  logic        last_of_fragment;
  logic        fault;

  modport source (output valid, output frag_byte, output frag_sequence,
                  output byte_position, output record_total,
                  output last_of_fragment, output fault, input ready);
  modport sink   (input valid, input frag_byte, input frag_sequence,
                  input byte_position, input record_total,
                  input last_of_fragment, input fault, output ready);
endinterface

FILE: rtl/cpfd_cfg_if.sv
// ----------------------------------------------------------------------------
// cpfd_cfg_if
// Configuration register write channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/cpfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// cpfd_cfg_regs
// Configuration registers: desk channel and maximum fragment total.
// ----------------------------------------------------------------------------
module cpfd_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  cpfd_cfg_if.sink          cfg,
  output cpfd_pkg::cfg_t    cfg_o
);

  cpfd_pkg::cfg_t cfg_r;

  assign cfg.ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.desk_channel   <= cpfd_pkg::DESK_CHANNEL_RST;
      cfg_r.max_total_size <= cpfd_pkg::MAX_TOTAL_SIZE_RST;
    end else if (cfg.valid) begin
      // unknown indexes drop silently
      case (cfg.index)
        cpfd_pkg::CFG_DESK_CHANNEL:   cfg_r.desk_channel   <= cfg.data;
        cpfd_pkg::CFG_MAX_TOTAL_SIZE: cfg_r.max_total_size <= cfg.data[cpfd_pkg::TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/cpfd_in_reg.sv
// ----------------------------------------------------------------------------
// cpfd_in_reg
// Input register holding one stream byte until the parser takes it.
// ----------------------------------------------------------------------------
module cpfd_in_reg (
  input  logic        clk,
  input  logic        rst_n,
  cpfd_byte_if.sink   in_ch,
  input  logic        take,
  output logic        held_valid,
  output logic [7:0]  held_byte
);

  logic       valid_r;
  logic [7:0] byte_r;

  assign in_ch.ready = !valid_r || take;
  assign held_valid  = valid_r;
  assign held_byte   = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.stream_byte;
    end
  end

endmodule

FILE: rtl/cpfd_parser.sv
// ----------------------------------------------------------------------------
// cpfd_parser
// Packet and fragment header parser: one stream byte per step, at most one
// fragment byte or fault request out.
// ----------------------------------------------------------------------------
module cpfd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        stream_byte,
  input  cpfd_pkg::cfg_t    cfg,
  output cpfd_pkg::res_t    res
);

  localparam int PW = cpfd_pkg::POSITION_BITS;

  logic [2:0]    phase_r,   phase_nxt;
  logic [3:0]    fcnt_r,    fcnt_nxt;
  logic          halted_r,  halted_nxt;
  logic [31:0]   magic_r,   magic_nxt;
  logic [31:0]   len_r,     len_nxt;
  logic [31:0]   chan_r,    chan_nxt;
  logic [31:0]   seq_r,     seq_nxt;
  logic [31:0]   offset_r,  offset_nxt;
  logic [31:0]   total_r,   total_nxt;
  logic [PW-1:0] left_r,    left_nxt;
  logic [PW-1:0] pos_r,     pos_nxt;

  logic [31:0] rem;
  logic [31:0] len_full;
  logic [31:0] chan_full;
  logic [31:0] total_full;
  logic [31:0] len_limit;
  logic [31:0] max_total;
  logic        bad_bounds;

  function automatic logic [31:0] put_le(input logic [31:0] w, input logic [1:0] idx,
                                         input logic [7:0] b);
    logic [31:0] r;
    if (idx == 2'd0) begin
      r = {24'd0, b};
    end else begin
      r = w | ({24'd0, b} << {idx, 3'b000});
    end
    return r;
  endfunction

  always_comb begin
    phase_nxt  = phase_r;
    fcnt_nxt   = fcnt_r;
    halted_nxt = halted_r;
    magic_nxt  = magic_r;
    len_nxt    = len_r;
    chan_nxt   = chan_r;
    seq_nxt    = seq_r;
    offset_nxt = offset_r;
    total_nxt  = total_r;
    left_nxt   = left_r;
    pos_nxt    = pos_r;
    res        = '0;

    rem        = len_r - 32'd1;
    len_full   = put_le(len_r, fcnt_r[1:0], stream_byte);
    chan_full  = put_le(chan_r, fcnt_r[1:0], stream_byte);
    total_full = put_le(total_r, fcnt_r[1:0], stream_byte);
    max_total  = 32'(cfg.max_total_size);
    len_limit  = max_total + cpfd_pkg::LENGTH_SLACK;
    bad_bounds = (total_full == 32'd0) || (total_full > max_total) ||
                 (offset_r > total_full) || (rem > total_full - offset_r);

    if (!halted_r) begin
      case (phase_r)
        cpfd_pkg::PH_HEADER: begin
          // version bytes carry no effect and are not kept
          if (fcnt_r >= cpfd_pkg::FC_WORD2_START) begin
            len_nxt = len_full;
          end else if (fcnt_r >= cpfd_pkg::FC_WORD1_START) begin
            magic_nxt = put_le(magic_r, fcnt_r[1:0], stream_byte);
          end
          if (fcnt_r != cpfd_pkg::FC_GROUP_LAST) begin
            fcnt_nxt = fcnt_r + 4'd1;
          end else begin
            fcnt_nxt = '0;
            if (len_full > len_limit) begin
              halted_nxt     = 1'b1;
              res.valid      = 1'b1;
              res.frag.fault = 1'b1;
            end else if (len_full == 32'd0) begin
              phase_nxt = cpfd_pkg::PH_HEADER;
            end else if (magic_r == cpfd_pkg::DATA_MAGIC && len_full >= cpfd_pkg::MIN_CHAN_LEN) begin
              phase_nxt = cpfd_pkg::PH_CHANNEL;
            end else begin
              phase_nxt = cpfd_pkg::PH_SKIP;
            end
          end
        end

        cpfd_pkg::PH_CHANNEL: begin
          len_nxt  = rem;
          chan_nxt = chan_full;
          fcnt_nxt = fcnt_r + 4'd1;
          if (fcnt_r == cpfd_pkg::FC_WORD_LAST) begin
            fcnt_nxt = '0;
            if (chan_full == cfg.desk_channel && rem >= cpfd_pkg::GROUP_BYTES) begin
              phase_nxt = cpfd_pkg::PH_FRAGHDR;
            end else begin
              phase_nxt = (rem == 32'd0) ? cpfd_pkg::PH_HEADER : cpfd_pkg::PH_SKIP;
            end
          end
        end

        cpfd_pkg::PH_FRAGHDR: begin
          len_nxt = rem;
          if (fcnt_r >= cpfd_pkg::FC_WORD2_START) begin
            total_nxt = total_full;
          end else if (fcnt_r >= cpfd_pkg::FC_WORD1_START) begin
            offset_nxt = put_le(offset_r, fcnt_r[1:0], stream_byte);
          end else begin
            seq_nxt = put_le(seq_r, fcnt_r[1:0], stream_byte);
          end
          if (fcnt_r != cpfd_pkg::FC_GROUP_LAST) begin
            fcnt_nxt = fcnt_r + 4'd1;
          end else begin
            fcnt_nxt = '0;
            if (bad_bounds || rem == 32'd0) begin
              phase_nxt = (rem == 32'd0) ? cpfd_pkg::PH_HEADER : cpfd_pkg::PH_SKIP;
            end else begin
              left_nxt  = rem[PW-1:0];
              pos_nxt   = offset_r[PW-1:0];
              phase_nxt = cpfd_pkg::PH_DATA;
            end
          end
        end

        cpfd_pkg::PH_DATA: begin
          len_nxt                    = rem;
          res.valid                  = 1'b1;
          res.frag.frag_byte         = stream_byte;
          res.frag.frag_sequence     = seq_r;
          res.frag.byte_position     = cpfd_pkg::TOTAL_W'(pos_r);
          res.frag.record_total      = total_r[cpfd_pkg::TOTAL_W-1:0];
          res.frag.last_of_fragment  = (left_r == PW'(1));
          pos_nxt                    = pos_r + PW'(1);
          left_nxt                   = left_r - PW'(1);
          if (rem == 32'd0 || left_nxt == '0) begin
            fcnt_nxt  = '0;
            phase_nxt = (rem == 32'd0) ? cpfd_pkg::PH_HEADER : cpfd_pkg::PH_SKIP;
          end
        end

        default: begin
          // skip the rest of the payload
          len_nxt = rem;
          if (rem == 32'd0) begin
            fcnt_nxt  = '0;
            phase_nxt = cpfd_pkg::PH_HEADER;
          end else begin
            phase_nxt = cpfd_pkg::PH_SKIP;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= cpfd_pkg::PH_HEADER;
      fcnt_r   <= '0;
      halted_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      fcnt_r   <= fcnt_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      magic_r  <= magic_nxt;
      len_r    <= len_nxt;
      chan_r   <= chan_nxt;
      seq_r    <= seq_nxt;
      offset_r <= offset_nxt;
      total_r  <= total_nxt;
      left_r   <= left_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

FILE: rtl/cpfd_out_reg.sv
// ----------------------------------------------------------------------------
// cpfd_out_reg
// Result register driving the fragment channel.
// ----------------------------------------------------------------------------
module cpfd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  cpfd_pkg::frag_t  frag_i,
  output logic             slot_free,
  cpfd_frag_if.source      out_ch
);

  logic            valid_r;
  cpfd_pkg::frag_t frag_r;

  assign slot_free = !valid_r || out_ch.ready;

  assign out_ch.valid            = valid_r;
  assign out_ch.frag_byte        = frag_r.frag_byte;
  assign out_ch.frag_sequence    = frag_r.frag_sequence;
  assign out_ch.byte_position    = frag_r.byte_position;
  assign out_ch.record_total     = frag_r.record_total;
  assign out_ch.last_of_fragment = frag_r.last_of_fragment;
  assign out_ch.fault            = frag_r.fault;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frag_r <= frag_i;
    end
  end

endmodule

FILE: rtl/channel_packet_fragment_deframer.sv
// ----------------------------------------------------------------------------
// channel_packet_fragment_deframer
// Parses a received byte stream into packets and emits the data bytes of
// desktop fragments on the selected channel.
//
// Channels: in_stream takes one stream byte per request; out_frag gives one
// fragment byte per request with its sequence, absolute position, record
// total and last mark, or a single fault request; cfg_wr writes desk_channel
// (index 0) and max_total_size (index 1) and is always ready.
// Path: a byte that yields a result is taken into the input register, and its
// result enters the result register when the parser steps on that byte.
// Throughput: one byte per clock unless a result waits on a held out_frag, set
// by the single parser stage; header and skipped bytes yield no request but take the same slot.
// Reset: rst_n (synchronous) empties both registers, returns the parser to
// the packet header and restores register defaults.
// Stall: while out_frag is held, the pending result waits in the result
// register; the input register holds one more byte and in_stream drops ready
// only when that byte would produce a result too. After a fault request,
// bytes are accepted and dropped until reset.
// ----------------------------------------------------------------------------
module channel_packet_fragment_deframer (
  input  logic         clk,
  input  logic         rst_n,
  cpfd_byte_if.sink    in_stream,
  cpfd_frag_if.source  out_frag,
  cpfd_cfg_if.sink     cfg_wr
);

  cpfd_pkg::cfg_t cfg;
  cpfd_pkg::res_t res;
  logic           held_valid;
  logic [7:0]     held_byte;
  logic           slot_free;
  logic           step;

  // advance the parser unless its result would collide with a stalled one
  assign step = held_valid && (!res.valid || slot_free);

  cpfd_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_wr),
    .cfg_o (cfg)
  );

  cpfd_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_stream),
    .take       (step),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  cpfd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .stream_byte (held_byte),
    .cfg         (cfg),
    .res         (res)
  );

  cpfd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res.valid),
    .frag_i    (res.frag),
    .slot_free (slot_free),
    .out_ch    (out_frag)
  );

endmodule

FILE: rtl/cpfd_checker.sv
// ----------------------------------------------------------------------------
// cpfd_checker
// Port-level checks of the fragment deframer, bound to the top level.
// ----------------------------------------------------------------------------
module cpfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  frag_byte,
  input logic [31:0] frag_sequence,
  input logic [21:0] byte_position,
  input logic [21:0] record_total,
  input logic        last_of_fragment,
  input logic        fault
);

  // a stalled request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(frag_byte) &&
      $stable(frag_sequence) && $stable(byte_position) && $stable(fault))
    else $error("stalled result request changed");

  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fault |-> frag_byte == 8'd0 && frag_sequence == 32'd0 &&
      byte_position == 22'd0 && record_total == 22'd0 && !last_of_fragment)
    else $error("fault request carries fragment fields");

  a_pos_in_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !fault |-> record_total != 22'd0 && byte_position < record_total)
    else $error("fragment byte outside its record");

  // nothing follows the fault until reset
  a_quiet_after_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && fault |=> !out_valid)
    else $error("result request after fault");

endmodule

bind channel_packet_fragment_deframer cpfd_checker u_cpfd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_frag.valid),
  .out_ready        (out_frag.ready),
  .frag_byte        (out_frag.frag_byte),
  .frag_sequence    (out_frag.frag_sequence),
  .byte_position    (out_frag.byte_position),
  .record_total     (out_frag.record_total),
  .last_of_fragment (out_frag.last_of_fragment),
  .fault            (out_frag.fault)
);
